@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ptds_pkg.sv @@
// ----------------------------------------------------------------------------
// ptds_pkg
// shared widths, field offsets, codes and types of the texel depth shader
// ----------------------------------------------------------------------------
package ptds_pkg;

  localparam int COORD_W = 12;
  localparam int DIFF_W  = 13;
  localparam int PIX_W   = 8;
  localparam int ATTR_W  = 16;
  localparam int TIDX_W  = 12;
  localparam int COLOR_W = 32;
  localparam int DEPTH_W = 16;
  localparam int SLOT_W  = 2;
  localparam int FUNC_W  = 2;

  localparam int EW     = 30;
  localparam int RCP_W  = 25;
  localparam int MA_W   = 30;
  localparam int MB_W   = 26;
  localparam int PROD_W = 56;
  localparam int NS_W   = 57;
  localparam int DEN_W  = 56;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 64;

  localparam int IN_SLOT_LO = 0;
  localparam int IN_X_LO    = 2;
  localparam int IN_Y_LO    = 14;
  localparam int IN_W_LO    = 26;
  localparam int IN_U_LO    = 42;
  localparam int IN_V_LO    = 58;
  localparam int IN_PX_LO   = 74;
  localparam int IN_PY_LO   = 82;
  localparam int IN_TI_LO   = 90;
  localparam int IN_COL_LO  = 102;

  localparam logic [DEPTH_W-1:0] DEPTH_FAR  = 16'hFFFF;
  localparam logic [RCP_W-1:0]   RCP_ONE    = 25'd65536;
  localparam logic [RCP_W-1:0]   DIV_ONE24  = 25'h100_0000;
  localparam logic [16:0]        DEPTH_SPAN = 17'd65536;
  localparam logic [SLOT_W-1:0]  SLOT_NONE  = 2'd3;

  typedef enum logic [FUNC_W-1:0] {
    FN_VERTEX = 2'd0,
    FN_SHADE  = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_TEXEL  = 2'd3
  } func_e;

  typedef struct packed {
    logic rd;
    logic wr;
  } dreq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/ptds_div.sv @@
// ----------------------------------------------------------------------------
// ptds_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ptds_div #(
  parameter int unsigned NUM_W = 67,
  parameter int unsigned DEN_W = 56
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DEN_W-1:0]      den_i,
  output ptds_pkg::div_stat_t   stat_o,
  output logic [NUM_W-1:0]      quo_o,
  output logic                  rem_nz_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = !diff[DEN_W+1];

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i && cnt_q == '0) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[DEN_W:0] : rem_sh;
      num_d  = {num_q[NUM_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quo_o       = num_q;
  assign rem_nz_o    = |rem_q;

endmodule

@@ src/ptds_depth_store.sv @@
// ----------------------------------------------------------------------------
// ptds_depth_store
// depth buffer memory with a clearing sweep to farthest after reset
// ----------------------------------------------------------------------------
module ptds_depth_store #(
  parameter int unsigned ENTRIES = 65536,
  localparam int unsigned AW = $clog2(ENTRIES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptds_pkg::dreq_t               req_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic [ptds_pkg::DEPTH_W-1:0]  wdata_i,
  output logic [ptds_pkg::DEPTH_W-1:0]  rdata_o,
  output logic                          busy_o
);

  logic [ptds_pkg::DEPTH_W-1:0] mem [ENTRIES];
  logic [AW:0]                  clr_q, clr_d;
  logic                         we;
  logic [AW-1:0]                wa;
  logic [ptds_pkg::DEPTH_W-1:0] wd;

  assign busy_o = (clr_q < (AW+1)'(ENTRIES));
  assign clr_d  = busy_o ? clr_q + 1'b1 : clr_q;
  assign we     = busy_o || req_i.wr;
  assign wa     = busy_o ? clr_q[AW-1:0] : addr_i;
  assign wd     = busy_o ? ptds_pkg::DEPTH_FAR : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req_i.rd) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

@@ src/perspective_texel_depth_shader.sv @@
// ----------------------------------------------------------------------------
// perspective_texel_depth_shader
// perspective-correct texel fetch and depth test for one triangle pixel
// ----------------------------------------------------------------------------
// usage: one stream of commands in (tuser selects vertex load, pixel shade,
// depth clear or texel load), one stream of pixel results out.
// only a shade gives a result: draw flag in tuser, x, y, color and depth.
// clear and texel load are done in the idle state as they are taken; a vertex
// load runs three divides. a shade runs multiply-accumulate steps on one shared
// 30x26 multiplier plus up to three divides on the shared radix-2 divider.
// one command is worked on at a time; the result sits in an output register,
// so the next command is taken while the receiver stalls, and only the
// following result waits on it.
// after reset the depth memory is swept to farthest, one entry per cycle,
// over all SCREEN_WIDTH * SCREEN_HEIGHT entries; no command is taken until then.
// the texture memory has no reset and must be loaded before it is used.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module perspective_texel_depth_shader #(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 256,
  parameter int unsigned TEX_WIDTH     = 64,
  parameter int unsigned TEX_HEIGHT    = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // vertex_slot, vertex_x, vertex_y, vertex_w, vertex_u, vertex_v,
  // pixel_x, pixel_y, texel_index, texel_color, zero pad
  input  logic [ptds_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // func
  input  logic [ptds_pkg::FUNC_W-1:0]       s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_x, out_y, out_color, out_depth
  output logic [ptds_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // draw
  output logic [0:0]                        m_axis_tuser_o
);

  localparam int unsigned DEPTH_N = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned DAW     = $clog2(DEPTH_N);
  localparam int unsigned TEX_N   = TEX_WIDTH * TEX_HEIGHT;
  localparam int unsigned TXB     = $clog2(TEX_WIDTH);
  localparam int unsigned TYB     = $clog2(TEX_HEIGHT);
  localparam int unsigned TAW     = TXB + TYB;
  localparam int unsigned TMAX    = (TXB > TYB) ? TXB : TYB;
  localparam int unsigned NUM_W   = ptds_pkg::NS_W + TMAX;

  localparam int NS  = ptds_pkg::NS_W;
  localparam int EW  = ptds_pkg::EW;
  localparam int DW  = ptds_pkg::DIFF_W;
  localparam int RW  = ptds_pkg::RCP_W;
  localparam int DPW = ptds_pkg::DEPTH_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VDIV   = 4'd1;
  localparam logic [3:0] S_CROSS  = 4'd2;
  localparam logic [3:0] S_FIX    = 4'd3;
  localparam logic [3:0] S_INTERP = 4'd4;
  localparam logic [3:0] S_NRCHK  = 4'd5;
  localparam logic [3:0] S_DIVR   = 4'd6;
  localparam logic [3:0] S_DIVX   = 4'd7;
  localparam logic [3:0] S_DIVY   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  localparam logic [3:0] TG_AREA_A = 4'd0;
  localparam logic [3:0] TG_AREA_B = 4'd1;
  localparam logic [3:0] TG_E0_A   = 4'd2;
  localparam logic [3:0] TG_E0_B   = 4'd3;
  localparam logic [3:0] TG_E1_A   = 4'd4;
  localparam logic [3:0] TG_E1_B   = 4'd5;
  localparam logic [3:0] TG_NR     = 4'd6;
  localparam logic [3:0] TG_NU     = 4'd9;
  localparam logic [3:0] TG_NV     = 4'd12;
  localparam logic [3:0] TG_LAST   = 4'd14;

  localparam logic [3:0] N_CROSS  = 4'd6;
  localparam logic [3:0] N_INTERP = 4'd9;
  localparam logic [3:0] V_LAST   = 4'd2;

  // input fields
  ptds_pkg::func_e                 in_func;
  logic [ptds_pkg::SLOT_W-1:0]     in_slot;
  logic signed [ptds_pkg::COORD_W-1:0] in_x, in_y;
  logic [ptds_pkg::ATTR_W-1:0]     in_w, in_u, in_v;
  logic [ptds_pkg::PIX_W-1:0]      in_px, in_py;
  logic [ptds_pkg::TIDX_W-1:0]     in_ti;
  logic [ptds_pkg::COLOR_W-1:0]    in_col;
  logic                            in_fire, in_on, in_tex_ok;
  logic [DAW-1:0]                  in_addr;

  assign in_func = ptds_pkg::func_e'(s_axis_tuser_i);
  assign in_slot = s_axis_tdata_i[ptds_pkg::IN_SLOT_LO +: ptds_pkg::SLOT_W];
  assign in_x    = s_axis_tdata_i[ptds_pkg::IN_X_LO +: ptds_pkg::COORD_W];
  assign in_y    = s_axis_tdata_i[ptds_pkg::IN_Y_LO +: ptds_pkg::COORD_W];
  assign in_w    = s_axis_tdata_i[ptds_pkg::IN_W_LO +: ptds_pkg::ATTR_W];
  assign in_u    = s_axis_tdata_i[ptds_pkg::IN_U_LO +: ptds_pkg::ATTR_W];
  assign in_v    = s_axis_tdata_i[ptds_pkg::IN_V_LO +: ptds_pkg::ATTR_W];
  assign in_px   = s_axis_tdata_i[ptds_pkg::IN_PX_LO +: ptds_pkg::PIX_W];
  assign in_py   = s_axis_tdata_i[ptds_pkg::IN_PY_LO +: ptds_pkg::PIX_W];
  assign in_ti   = s_axis_tdata_i[ptds_pkg::IN_TI_LO +: ptds_pkg::TIDX_W];
  assign in_col  = s_axis_tdata_i[ptds_pkg::IN_COL_LO +: ptds_pkg::COLOR_W];

  assign in_on = (13'(in_px) < 13'(SCREEN_WIDTH)) && (13'(in_py) < 13'(SCREEN_HEIGHT));
  assign in_tex_ok = (21'(in_ti) < 21'(TEX_N));
  assign in_addr = DAW'(in_py) * DAW'(SCREEN_WIDTH) + DAW'(in_px);

  // state
  logic [3:0] st_q, st_d;
  logic [3:0] cnt_q, cnt_d;
  logic       start_q, start_d;
  logic       pv_q, pv_d;
  logic [3:0] tag_q, tag_d;
  logic signed [ptds_pkg::PROD_W-1:0] p_q, p_d;

  logic signed [ptds_pkg::COORD_W-1:0] posx_q [3], posx_d [3];
  logic signed [ptds_pkg::COORD_W-1:0] posy_q [3], posy_d [3];
  logic [RW-1:0] rw_q [3], rw_d [3];
  logic [RW-1:0] ru_q [3], ru_d [3];
  logic [RW-1:0] rv_q [3], rv_d [3];

  logic [ptds_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [ptds_pkg::ATTR_W-1:0] wv_q, wv_d, uu_q, uu_d, vv_q, vv_d;
  logic [ptds_pkg::PIX_W-1:0]  px_q, px_d, py_q, py_d;
  logic [DAW-1:0]              daddr_q, daddr_d;
  logic signed [EW-1:0] area_q, area_d, e0_q, e0_d, e1_q, e1_d, e2_q, e2_d;
  logic signed [NS-1:0] nr_q, nr_d, nu_q, nu_d, nv_q, nv_d;
  logic [DPW-1:0] depth_q, depth_d;
  logic           draw_q, draw_d;
  logic [TXB-1:0] tx_q, tx_d;

  logic                        ovalid_q, ovalid_d;
  logic                        odraw_q, odraw_d;
  logic [ptds_pkg::PIX_W-1:0]  ox_q, ox_d, oy_q, oy_d;
  logic [ptds_pkg::COLOR_W-1:0] ocol_q, ocol_d;
  logic [DPW-1:0]              odep_q, odep_d;

  // memories and helpers
  ptds_pkg::dreq_t      dreq;
  logic [DAW-1:0]       dmem_addr;
  logic [DPW-1:0]       dmem_wdata, drd;
  logic                 dbusy;

  logic [ptds_pkg::COLOR_W-1:0] tex_mem [TEX_N];
  logic [ptds_pkg::COLOR_W-1:0] tex_rd;
  logic                         tex_we, tex_re;
  logic [TAW-1:0]               tex_raddr;

  ptds_pkg::div_stat_t div_stat;
  logic [NUM_W-1:0]    div_num, quo;
  logic [ptds_pkg::DEN_W-1:0] div_den;
  logic                rem_nz;

  // edge differences
  logic signed [DW-1:0] sx, sy;
  logic signed [DW-1:0] d_cxax, d_byay, d_cyay, d_bxax;
  logic signed [DW-1:0] d_cxx, d_byy, d_cyy, d_bxx, d_yay, d_xax;

  assign sx = $signed({{(DW-ptds_pkg::PIX_W){1'b0}}, px_q});
  assign sy = $signed({{(DW-ptds_pkg::PIX_W){1'b0}}, py_q});
  assign d_cxax = DW'(posx_q[2]) - DW'(posx_q[0]);
  assign d_byay = DW'(posy_q[1]) - DW'(posy_q[0]);
  assign d_cyay = DW'(posy_q[2]) - DW'(posy_q[0]);
  assign d_bxax = DW'(posx_q[1]) - DW'(posx_q[0]);
  assign d_cxx  = DW'(posx_q[2]) - sx;
  assign d_byy  = DW'(posy_q[1]) - sy;
  assign d_cyy  = DW'(posy_q[2]) - sy;
  assign d_bxx  = DW'(posx_q[1]) - sx;
  assign d_yay  = sy - DW'(posy_q[0]);
  assign d_xax  = sx - DW'(posx_q[0]);

  // shared multiplier
  logic signed [ptds_pkg::MA_W-1:0] ma;
  logic signed [ptds_pkg::MB_W-1:0] mb;
  logic                             issue;
  logic [3:0]                       tag;

  always_comb begin
    ma    = '0;
    mb    = '0;
    issue = 1'b0;
    tag   = cnt_q;
    if (st_q == S_CROSS && cnt_q < N_CROSS) begin
      issue = 1'b1;
      case (cnt_q)
        TG_AREA_A: begin ma = ptds_pkg::MA_W'(d_cxax); mb = ptds_pkg::MB_W'(d_byay); end
        TG_AREA_B: begin ma = ptds_pkg::MA_W'(d_cyay); mb = ptds_pkg::MB_W'(d_bxax); end
        TG_E0_A:   begin ma = ptds_pkg::MA_W'(d_cxx);  mb = ptds_pkg::MB_W'(d_byy);  end
        TG_E0_B:   begin ma = ptds_pkg::MA_W'(d_cyy);  mb = ptds_pkg::MB_W'(d_bxx);  end
        TG_E1_A:   begin ma = ptds_pkg::MA_W'(d_cxax); mb = ptds_pkg::MB_W'(d_yay);  end
        default:   begin ma = ptds_pkg::MA_W'(d_cyay); mb = ptds_pkg::MB_W'(d_xax);  end
      endcase
    end else if (st_q == S_INTERP && cnt_q < N_INTERP) begin
      issue = 1'b1;
      tag   = cnt_q + TG_NR;
      case (cnt_q)
        4'd0:    begin ma = e0_q; mb = $signed({1'b0, rw_q[0]}); end
        4'd1:    begin ma = e1_q; mb = $signed({1'b0, rw_q[1]}); end
        4'd2:    begin ma = e2_q; mb = $signed({1'b0, rw_q[2]}); end
        4'd3:    begin ma = e0_q; mb = $signed({1'b0, ru_q[0]}); end
        4'd4:    begin ma = e1_q; mb = $signed({1'b0, ru_q[1]}); end
        4'd5:    begin ma = e2_q; mb = $signed({1'b0, ru_q[2]}); end
        4'd6:    begin ma = e0_q; mb = $signed({1'b0, rv_q[0]}); end
        4'd7:    begin ma = e1_q; mb = $signed({1'b0, rv_q[1]}); end
        default: begin ma = e2_q; mb = $signed({1'b0, rv_q[2]}); end
      endcase
    end
  end

  assign p_d   = ma * mb;
  assign pv_d  = issue;
  assign tag_d = tag;

  // divider operands
  logic [NS-1:0] nu_mag, nv_mag;
  assign nu_mag = nu_q[NS-1] ? NS'(-nu_q) : NS'(nu_q);
  assign nv_mag = nv_q[NS-1] ? NS'(-nv_q) : NS'(nv_q);

  always_comb begin
    div_num = '0;
    div_den = ptds_pkg::DEN_W'(wv_q);
    case (st_q)
      S_VDIV: begin
        case (cnt_q)
          4'd0:    div_num = NUM_W'(ptds_pkg::DIV_ONE24);
          4'd1:    div_num = NUM_W'({uu_q, 8'h00});
          default: div_num = NUM_W'({vv_q, 8'h00});
        endcase
      end
      S_DIVR: begin
        div_num = NUM_W'($unsigned(nr_q));
        div_den = ptds_pkg::DEN_W'($unsigned(area_q));
      end
      S_DIVX: begin
        div_num = NUM_W'(nu_mag) << TXB;
        div_den = ptds_pkg::DEN_W'($unsigned(nr_q));
      end
      S_DIVY: begin
        div_num = NUM_W'(nv_mag) << TYB;
        div_den = ptds_pkg::DEN_W'($unsigned(nr_q));
      end
      default: div_num = '0;
    endcase
  end

  ptds_div #(
    .NUM_W (NUM_W),
    .DEN_W (ptds_pkg::DEN_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .num_i    (div_num),
    .den_i    (div_den),
    .stat_o   (div_stat),
    .quo_o    (quo),
    .rem_nz_o (rem_nz)
  );

  // depth from quotient
  logic [DPW-1:0] dnew;
  logic           q_big;
  assign q_big = |quo[NUM_W-1:17];
  always_comb begin
    if (q_big || quo[16:0] > ptds_pkg::DEPTH_SPAN) begin
      dnew = '0;
    end else if (quo[16:0] == '0) begin
      dnew = ptds_pkg::DEPTH_FAR;
    end else begin
      dnew = DPW'(ptds_pkg::DEPTH_SPAN - quo[16:0]);
    end
  end

  // wrapped texel coordinates
  logic [TXB-1:0] qx_lo, tx_now;
  logic [TYB-1:0] qy_lo, ty_now;
  assign qx_lo  = quo[TXB-1:0] + TXB'(nu_q[NS-1] & rem_nz);
  assign tx_now = nu_q[NS-1] ? (~qx_lo + TXB'(1)) : qx_lo;
  assign qy_lo  = quo[TYB-1:0] + TYB'(nv_q[NS-1] & rem_nz);
  assign ty_now = nv_q[NS-1] ? (~qy_lo + TYB'(1)) : qy_lo;

  assign s_axis_tready_o = (st_q == S_IDLE) && !dbusy;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    start_d = 1'b0;
    posx_d  = posx_q;
    posy_d  = posy_q;
    rw_d    = rw_q;
    ru_d    = ru_q;
    rv_d    = rv_q;
    slot_d  = slot_q;
    wv_d    = wv_q;
    uu_d    = uu_q;
    vv_d    = vv_q;
    px_d    = px_q;
    py_d    = py_q;
    daddr_d = daddr_q;
    area_d  = area_q;
    e0_d    = e0_q;
    e1_d    = e1_q;
    e2_d    = e2_q;
    nr_d    = nr_q;
    nu_d    = nu_q;
    nv_d    = nv_q;
    depth_d = depth_q;
    draw_d  = draw_q;
    tx_d    = tx_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    odraw_d = odraw_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    ocol_d  = ocol_q;
    odep_d  = odep_q;
    dreq       = '0;
    dmem_addr  = daddr_q;
    dmem_wdata = ptds_pkg::DEPTH_FAR;
    tex_we     = 1'b0;
    tex_re     = 1'b0;
    tex_raddr  = {ty_now, tx_q};

    if (pv_q) begin
      case (tag_q) inside
        TG_AREA_A: area_d = area_q + EW'(p_q);
        TG_AREA_B: area_d = area_q - EW'(p_q);
        TG_E0_A:   e0_d   = e0_q + EW'(p_q);
        TG_E0_B:   e0_d   = e0_q - EW'(p_q);
        TG_E1_A:   e1_d   = e1_q + EW'(p_q);
        TG_E1_B:   e1_d   = e1_q - EW'(p_q);
        [TG_NR:TG_NU-4'd1]: nr_d = nr_q + NS'(p_q);
        [TG_NU:TG_NV-4'd1]: nu_d = nu_q + NS'(p_q);
        [TG_NV:TG_LAST]:    nv_d = nv_q + NS'(p_q);
        default: ;
      endcase
    end

    case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            ptds_pkg::FN_VERTEX: begin
              if (in_slot != ptds_pkg::SLOT_NONE) begin
                posx_d[in_slot] = in_x;
                posy_d[in_slot] = in_y;
                slot_d  = in_slot;
                wv_d    = (in_w == '0) ? ptds_pkg::ATTR_W'(1) : in_w;
                uu_d    = in_u;
                vv_d    = in_v;
                cnt_d   = '0;
                start_d = 1'b1;
                st_d    = S_VDIV;
              end
            end
            ptds_pkg::FN_SHADE: begin
              px_d    = in_px;
              py_d    = in_py;
              daddr_d = in_addr;
              area_d  = '0;
              e0_d    = '0;
              e1_d    = '0;
              draw_d  = 1'b0;
              cnt_d   = '0;
              if (in_on) begin
                dreq.rd   = 1'b1;
                dmem_addr = in_addr;
                st_d      = S_CROSS;
              end else begin
                st_d = S_OUT;
              end
            end
            ptds_pkg::FN_CLEAR: begin
              if (in_on) begin
                dreq.wr   = 1'b1;
                dmem_addr = in_addr;
              end
            end
            default: begin
              tex_we = in_tex_ok;
            end
          endcase
        end
      end
      S_VDIV: begin
        if (div_stat.done) begin
          case (cnt_q)
            4'd0:    rw_d[slot_q] = quo[RW-1:0];
            4'd1:    ru_d[slot_q] = quo[RW-1:0];
            default: rv_d[slot_q] = quo[RW-1:0];
          endcase
          if (cnt_q == V_LAST) begin
            st_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + 4'd1;
            start_d = 1'b1;
          end
        end
      end
      S_CROSS: begin
        if (cnt_q == N_CROSS) begin
          cnt_d = '0;
          st_d  = S_FIX;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_FIX: begin
        nr_d = '0;
        nu_d = '0;
        nv_d = '0;
        if (area_q == '0) begin
          st_d = S_OUT;
        end else begin
          if (area_q[EW-1]) begin
            area_d = -area_q;
            e0_d   = -e0_q;
            e1_d   = -e1_q;
            e2_d   = e0_q + e1_q - area_q;
          end else begin
            e2_d = area_q - e0_q - e1_q;
          end
          st_d = S_INTERP;
        end
      end
      S_INTERP: begin
        if (cnt_q == N_INTERP) begin
          cnt_d = '0;
          st_d  = S_NRCHK;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_NRCHK: begin
        if (nr_q[NS-1] || nr_q == '0) begin
          st_d = S_OUT;
        end else begin
          start_d = 1'b1;
          st_d    = S_DIVR;
        end
      end
      S_DIVR: begin
        if (div_stat.done) begin
          depth_d = dnew;
          if (dnew < drd) begin
            start_d = 1'b1;
            st_d    = S_DIVX;
          end else begin
            st_d = S_OUT;
          end
        end
      end
      S_DIVX: begin
        if (div_stat.done) begin
          tx_d    = tx_now;
          start_d = 1'b1;
          st_d    = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_stat.done) begin
          tex_re     = 1'b1;
          dreq.wr    = 1'b1;
          dmem_wdata = depth_q;
          draw_d     = 1'b1;
          st_d       = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          odraw_d  = draw_q;
          ox_d     = px_q;
          oy_d     = py_q;
          ocol_d   = draw_q ? tex_rd : '0;
          odep_d   = draw_q ? depth_q : '0;
          st_d     = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  ptds_depth_store #(
    .ENTRIES (DEPTH_N)
  ) u_depth (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dreq),
    .addr_i  (dmem_addr),
    .wdata_i (dmem_wdata),
    .rdata_o (drd),
    .busy_o  (dbusy)
  );

  always_ff @(posedge clk_i) begin
    if (tex_we) begin
      tex_mem[TAW'(in_ti)] <= in_col;
    end
    if (tex_re) begin
      tex_rd <= tex_mem[tex_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      cnt_q    <= '0;
      start_q  <= 1'b0;
      pv_q     <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        posx_q[i] <= '0;
        posy_q[i] <= '0;
        rw_q[i]   <= ptds_pkg::RCP_ONE;
        ru_q[i]   <= '0;
        rv_q[i]   <= '0;
      end
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      start_q  <= start_d;
      pv_q     <= pv_d;
      ovalid_q <= ovalid_d;
      posx_q   <= posx_d;
      posy_q   <= posy_d;
      rw_q     <= rw_d;
      ru_q     <= ru_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    p_q     <= p_d;
    slot_q  <= slot_d;
    wv_q    <= wv_d;
    uu_q    <= uu_d;
    vv_q    <= vv_d;
    px_q    <= px_d;
    py_q    <= py_d;
    daddr_q <= daddr_d;
    area_q  <= area_d;
    e0_q    <= e0_d;
    e1_q    <= e1_d;
    e2_q    <= e2_d;
    nr_q    <= nr_d;
    nu_q    <= nu_d;
    nv_q    <= nv_d;
    depth_q <= depth_d;
    draw_q  <= draw_d;
    tx_q    <= tx_d;
    odraw_q <= odraw_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    ocol_q  <= ocol_d;
    odep_q  <= odep_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = odraw_q;
  assign m_axis_tdata_o  = {odep_q, ocol_q, oy_q, ox_q};

  `ASSERT_IMPLIES(a_ready_after_sweep, clk_i, rst_ni, s_axis_tready_o, !dbusy,
    "command taken during depth sweep")
  `ASSERT_IMPLIES(a_div_start_free, clk_i, rst_ni, start_q, !div_stat.busy,
    "divider started while busy")
  `ASSERT_IMPLIES(a_nodraw_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0],
    m_axis_tdata_o[63:16] == '0, "rejected pixel carries color or depth")
  `ASSERT_NEXT(a_out_load, clk_i, rst_ni,
    st_q == S_OUT && (!ovalid_q || m_axis_tready_i),
    m_axis_tvalid_o && st_q == S_IDLE, "result not loaded")

endmodule
